@@ hw/rtl/seom_pkg.sv @@
// ============================================================================
// seom_pkg: shared types and constants for the static edge object map
// Frame geometry, memory widths, register map and the per-pixel control word.
// ============================================================================
package seom_pkg;

    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;
    localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int BG_FRAC    = 8;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int FRAME_W = 24;
    localparam int GRAD_W  = 11;
    localparam int BG_W    = GRAD_W + BG_FRAC + 1;
    localparam int CNT_W   = 8;

    localparam logic [15:0] INIT_RATE    = 16'd655;
    localparam logic [10:0] MIN_GRADIENT = 11'd20;
    localparam logic [7:0]  COUNT_GAIN   = 8'd2;

    // register map, index = byte address / 4
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FORE_THRESH  = 3'd2;
    localparam logic [2:0] REG_STATIC_TIME  = 3'd3;
    localparam logic [2:0] REG_HALF_STATIC  = 3'd4;
    localparam logic [2:0] REG_LEARN_FRAMES = 3'd5;
    localparam logic [2:0] REG_LEARN_RATE   = 3'd6;
    localparam logic [2:0] REG_DECAY_PERIOD = 3'd7;

    // control word for one pixel, built by the sequencer
    typedef struct packed {
        logic              first;
        logic              decay;
        logic              accum;
        logic              interior;
        logic              init_rate;
        logic              col0;
        logic              last_col;
        logic              fend;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] baddr;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  lcol;
    } px_t;

    typedef struct packed {
        logic             fore_x;
        logic             fore_y;
        logic [CNT_W-1:0] count;
        logic             static_pixel;
        logic             candidate_pixel;
        logic             fend;
    } res_t;

    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        dec_sat = (v != '0) ? v - CNT_W'(1) : v;
    endfunction

endpackage

@@ hw/rtl/seom_seq.sv @@
// ============================================================================
// seom_seq: raster sequencer
// Tracks column, row, frame number and decay phase; builds the pixel control word.
// ============================================================================
module seom_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [seom_pkg::COL_W-1:0]    frame_width,
    input  logic [seom_pkg::ROW_W-1:0]    frame_height,
    input  logic [15:0]                   learn_frames,
    input  logic [7:0]                    decay_period,
    output seom_pkg::px_t                 px
);

    logic [seom_pkg::COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [seom_pkg::ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [seom_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [7:0]                   phase_reg, phase_next;

    logic [seom_pkg::COL_W-1:0] w, col, bcol;
    logic [seom_pkg::ROW_W-1:0] h, row;
    logic [seom_pkg::ROW_W:0]   brow;
    logic [7:0]                 period;
    logic                       last_row;

    always_comb
    begin
        if (frame_width < seom_pkg::COL_W'(3))
            w = seom_pkg::COL_W'(3);
        else if (frame_width > seom_pkg::COL_W'(seom_pkg::MAX_WIDTH))
            w = seom_pkg::COL_W'(seom_pkg::MAX_WIDTH);
        else
            w = frame_width;
        if (frame_height < seom_pkg::ROW_W'(3))
            h = seom_pkg::ROW_W'(3);
        else if (frame_height > seom_pkg::ROW_W'(seom_pkg::MAX_HEIGHT))
            h = seom_pkg::ROW_W'(seom_pkg::MAX_HEIGHT);
        else
            h = frame_height;

        // a position beyond a shrunk size sticks to the last column / row
        col = (col_pos_reg < w) ? col_pos_reg : w - seom_pkg::COL_W'(1);
        row = (row_pos_reg < h) ? row_pos_reg : h - seom_pkg::ROW_W'(1);
        last_row = (row == h - seom_pkg::ROW_W'(1));

        px.col0      = (col == '0);
        px.last_col  = (col == w - seom_pkg::COL_W'(1));
        px.fend      = px.last_col && last_row;
        px.interior  = (row != '0) && !last_row && (col != '0) && !px.last_col;
        px.first     = (frame_reg == '0);
        px.decay     = !px.first && (phase_reg == '0);
        px.accum     = px.decay && (frame_reg > seom_pkg::FRAME_W'(learn_frames));
        px.init_rate = (frame_reg <= seom_pkg::FRAME_W'(learn_frames));
        px.col       = col;
        px.lcol      = px.last_col ? '0 : col + seom_pkg::COL_W'(1);
        px.addr      = seom_pkg::ADDR_W'(seom_pkg::ADDR_W'(row)
                       * seom_pkg::ADDR_W'(seom_pkg::MAX_WIDTH))
                       + seom_pkg::ADDR_W'(col);

        // row below; on the last column look two rows ahead at column 0
        brow = px.last_col ? {1'b0, row} + (seom_pkg::ROW_W+1)'(2)
                           : {1'b0, row} + (seom_pkg::ROW_W+1)'(1);
        bcol = px.last_col ? '0 : col + seom_pkg::COL_W'(1);
        if (brow < (seom_pkg::ROW_W+1)'(seom_pkg::MAX_HEIGHT))
            px.baddr = seom_pkg::ADDR_W'(seom_pkg::ADDR_W'(brow)
                       * seom_pkg::ADDR_W'(seom_pkg::MAX_WIDTH))
                       + seom_pkg::ADDR_W'(bcol);
        else
            px.baddr = '0;

        period = (decay_period == '0) ? 8'd1 : decay_period;

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        frame_next   = frame_reg;
        phase_next   = phase_reg;
        if (accept)
        begin
            if (px.last_col)
            begin
                col_pos_next = '0;
                if (last_row)
                begin
                    row_pos_next = '0;
                    if (frame_reg != '1)
                        frame_next = frame_reg + seom_pkg::FRAME_W'(1);
                    if ({1'b0, phase_reg} + 9'd1 >= {1'b0, period})
                        phase_next = '0;
                    else
                        phase_next = phase_reg + 8'd1;
                end
                else
                begin
                    row_pos_next = row + seom_pkg::ROW_W'(1);
                end
            end
            else
            begin
                col_pos_next = col + seom_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            frame_reg   <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            frame_reg   <= frame_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

@@ hw/rtl/seom_bg.sv @@
// ============================================================================
// seom_bg: background memory and blend
// One word per pixel holds both backgrounds; read on accept, blended, written back.
// ============================================================================
module seom_bg (
    input  logic                                clk,
    input  logic                                accept,
    input  logic                                s1_valid,
    input  seom_pkg::px_t                       px0,
    input  seom_pkg::px_t                       px1,
    input  logic signed [seom_pkg::GRAD_W-1:0]  gradient_x,
    input  logic signed [seom_pkg::GRAD_W-1:0]  gradient_y,
    input  logic [10:0]                         fore_threshold,
    input  logic [15:0]                         learn_rate,
    output logic                                fore_x,
    output logic                                fore_y
);

    localparam int D_W = seom_pkg::BG_W + 1;
    localparam int P_W = D_W + 17;

    logic [2*seom_pkg::BG_W-1:0] bg_mem [seom_pkg::PIXELS];

    logic [2*seom_pkg::BG_W-1:0]        bg_rd_reg;
    logic signed [seom_pkg::GRAD_W-1:0] gx_reg, gy_reg;

    logic [15:0]                 alpha;
    logic [seom_pkg::BG_W-1:0]   nbx, nby;

    // blend one direction; returns the moving-edge flag
    function automatic logic blend(
        input  logic signed [seom_pkg::GRAD_W-1:0] g,
        input  logic signed [seom_pkg::BG_W-1:0]   b,
        input  logic [15:0]                        a,
        input  logic                               first,
        input  logic                               interior,
        input  logic [10:0]                        thr,
        output logic [seom_pkg::BG_W-1:0]          nb
    );
        logic signed [D_W-1:0] gs, d, bw, step;
        logic signed [P_W-1:0] prod, rnd;
        logic [D_W-1:0]        ad;
        logic [seom_pkg::GRAD_W-1:0] ag;
        gs   = D_W'(g) <<< seom_pkg::BG_FRAC;
        bw   = D_W'(b);
        d    = gs - bw;
        prod = $signed({1'b0, a}) * d;
        rnd  = (prod + P_W'(32768)) >>> 16;
        step = D_W'(rnd);
        ad   = d[D_W-1] ? D_W'(-d) : D_W'(d);
        ag   = g[seom_pkg::GRAD_W-1] ? seom_pkg::GRAD_W'(-g) : seom_pkg::GRAD_W'(g);
        if (first)
        begin
            nb    = seom_pkg::BG_W'(gs);
            blend = 1'b0;
        end
        else
        begin
            nb    = seom_pkg::BG_W'(bw + step);
            blend = interior && (ad > (D_W'(thr) << seom_pkg::BG_FRAC))
                    && (ag >= seom_pkg::MIN_GRADIENT);
        end
    endfunction

    always_comb
    begin
        alpha  = px1.init_rate ? seom_pkg::INIT_RATE : learn_rate;
        fore_x = blend(gx_reg, $signed(bg_rd_reg[2*seom_pkg::BG_W-1:seom_pkg::BG_W]),
                       alpha, px1.first, px1.interior, fore_threshold, nbx);
        fore_y = blend(gy_reg, $signed(bg_rd_reg[seom_pkg::BG_W-1:0]),
                       alpha, px1.first, px1.interior, fore_threshold, nby);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bg_rd_reg <= bg_mem[px0.addr];
            gx_reg    <= gradient_x;
            gy_reg    <= gradient_y;
        end
        if (s1_valid)
            bg_mem[px1.addr] <= {nbx, nby};
    end

endmodule

@@ hw/rtl/seom_cnt.sv @@
// ============================================================================
// seom_cnt: static counter memory and neighbor window
// Counter map with two read ports, two line buffers, 3x3 raise, clear after reset.
// ============================================================================
module seom_cnt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        s1_valid,
    input  seom_pkg::px_t               px0,
    input  seom_pkg::px_t               px1,
    input  logic                        fore,
    input  logic [7:0]                  static_time,
    input  logic [7:0]                  half_static_time,
    output logic                        clear_busy,
    output logic [seom_pkg::CNT_W-1:0]  count
);

    logic [seom_pkg::CNT_W-1:0] cnt_mem [seom_pkg::PIXELS];
    logic [seom_pkg::CNT_W-1:0] lbn_mem [seom_pkg::MAX_WIDTH];  // this frame, row above
    logic [seom_pkg::CNT_W-1:0] lbo_mem [seom_pkg::MAX_WIDTH];  // stored, current row

    logic                        clr_busy_reg, clr_busy_next;
    logic [seom_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic [seom_pkg::CNT_W-1:0] rd_a_reg, rd_b_reg, lbn_rd_reg, lbo_rd_reg;
    logic [seom_pkg::CNT_W-1:0] a0_reg, a1_reg, b0_reg, b1_reg, left_reg;
    logic [seom_pkg::CNT_W-1:0] col0_last_reg, bcol0_reg;

    logic [seom_pkg::CNT_W-1:0] dec, gain, a1e, b1e;
    logic                       raise;

    assign clear_busy = clr_busy_reg;

    always_comb
    begin
        dec  = px1.decay ? seom_pkg::dec_sat(rd_a_reg) : rd_a_reg;
        gain = dec;
        if (fore)
            gain = (dec > 8'd253) ? 8'd255 : dec + seom_pkg::COUNT_GAIN;
        a1e = px1.col0 ? col0_last_reg : a1_reg;
        b1e = px1.col0 ? bcol0_reg : b1_reg;
        // left and upper neighbors already carry this frame's value
        raise = (a0_reg > static_time) || (a1e > static_time)
             || (lbn_rd_reg > static_time) || (left_reg > static_time)
             || (seom_pkg::dec_sat(lbo_rd_reg) > static_time)
             || (seom_pkg::dec_sat(b0_reg) > static_time)
             || (seom_pkg::dec_sat(b1e) > static_time)
             || (seom_pkg::dec_sat(rd_b_reg) > static_time);
        if (px1.accum && px1.interior)
        begin
            if (raise && (gain > half_static_time) && (gain < static_time))
                count = static_time;
            else
                count = gain;
        end
        else
        begin
            count = dec;
        end

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + seom_pkg::ADDR_W'(1);
            if (clr_addr_reg == seom_pkg::ADDR_W'(seom_pkg::PIXELS - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            cnt_mem[clr_addr_reg] <= '0;
        else if (s1_valid)
            cnt_mem[px1.addr] <= count;
        if (accept)
        begin
            rd_a_reg   <= cnt_mem[px0.addr];
            rd_b_reg   <= cnt_mem[px0.baddr];
            lbn_rd_reg <= lbn_mem[px0.lcol];
            lbo_rd_reg <= lbo_mem[px0.lcol];
        end
        if (s1_valid)
        begin
            lbn_mem[px1.col] <= count;
            if (!px1.last_col)
                lbo_mem[px1.lcol] <= rd_b_reg;
            a0_reg   <= a1e;
            a1_reg   <= lbn_rd_reg;
            b0_reg   <= b1e;
            b1_reg   <= rd_b_reg;
            left_reg <= count;
            if (px1.col0)
                col0_last_reg <= count;
            if (px1.last_col)
                bcol0_reg <= rd_b_reg;
        end
    end

endmodule

@@ hw/rtl/static_edge_object_map_top.sv @@
// ============================================================================
// static_edge_object_map_top: static edge object map
// Per-pixel gradient background, moving-edge flags and static counter map.
// ============================================================================
// Usage:
//   Pixel channel (pixel_valid / pixel_stall) takes gradient_x / gradient_y in
//   raster order. Result channel (result_valid / result_stall) returns one
//   transfer per pixel: fore flags, updated static count, static / candidate
//   flags and frame_end on the last pixel of a frame.
//   Result path: a pixel transfer is registered in the memory read stage, then
//   computed into the output queue; result_valid rises once the queue holds it.
//   Throughput: one pixel per cycle while pixel_stall is low; the single
//   read-modify-write pass of the background and counter memories sets that figure.
//   Reset: all control state clears, then the counter map is cleared one entry
//   per cycle, all 307200 entries, with pixel_stall high. Registers may be written
//   meanwhile. Backgrounds hold nothing until frame 0 loads them.
//   Receiver stall: results wait in a three-entry queue; pixel_stall rises when
//   the queue and the compute stage together hold three results, and during the counter clear.
//   Registers sit on an APB port at byte address 4 * index.
// ============================================================================
module static_edge_object_map_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // pixel channel
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic signed [seom_pkg::GRAD_W-1:0]  gradient_x,
    input  logic signed [seom_pkg::GRAD_W-1:0]  gradient_y,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                fore_x,
    output logic                                fore_y,
    output logic [seom_pkg::CNT_W-1:0]          static_count,
    output logic                                static_pixel,
    output logic                                candidate_pixel,
    output logic                                frame_end
);

    // configuration registers
    logic [9:0]  frame_width_reg;
    logic [8:0]  frame_height_reg;
    logic [10:0] fore_threshold_reg;
    logic [7:0]  static_time_reg;
    logic [7:0]  half_static_reg;
    logic [15:0] learn_frames_reg;
    logic [15:0] learn_rate_reg;
    logic [7:0]  decay_period_reg;
    logic        cfg_wr;

    // pipeline
    logic          pix_acc;
    logic          s1_valid_reg;
    seom_pkg::px_t px0, px1_reg;
    logic          fx, fy, clear_busy;
    logic [seom_pkg::CNT_W-1:0] count;

    // output queue
    seom_pkg::res_t q_mem [3];
    seom_pkg::res_t q_in, q_out;
    logic [1:0] q_count_reg, q_count_next;
    logic [1:0] q_wr_reg, q_rd_reg;
    logic       q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= 10'd640;
            frame_height_reg   <= 9'd480;
            fore_threshold_reg <= 11'd30;
            static_time_reg    <= 8'd120;
            half_static_reg    <= 8'd80;
            learn_frames_reg   <= 16'd50;
            learn_rate_reg     <= 16'd66;
            decay_period_reg   <= 8'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                seom_pkg::REG_FRAME_WIDTH:  frame_width_reg    <= pwdata[9:0];
                seom_pkg::REG_FRAME_HEIGHT: frame_height_reg   <= pwdata[8:0];
                seom_pkg::REG_FORE_THRESH:  fore_threshold_reg <= pwdata[10:0];
                seom_pkg::REG_STATIC_TIME:  static_time_reg    <= pwdata[7:0];
                seom_pkg::REG_HALF_STATIC:  half_static_reg    <= pwdata[7:0];
                seom_pkg::REG_LEARN_FRAMES: learn_frames_reg   <= pwdata[15:0];
                seom_pkg::REG_LEARN_RATE:   learn_rate_reg     <= pwdata[15:0];
                seom_pkg::REG_DECAY_PERIOD: decay_period_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            seom_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            seom_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            seom_pkg::REG_FORE_THRESH:  prdata = 32'(fore_threshold_reg);
            seom_pkg::REG_STATIC_TIME:  prdata = 32'(static_time_reg);
            seom_pkg::REG_HALF_STATIC:  prdata = 32'(half_static_reg);
            seom_pkg::REG_LEARN_FRAMES: prdata = 32'(learn_frames_reg);
            seom_pkg::REG_LEARN_RATE:   prdata = 32'(learn_rate_reg);
            seom_pkg::REG_DECAY_PERIOD: prdata = 32'(decay_period_reg);
            default:                    prdata = '0;
        endcase
    end

    // room check counts the result already in the compute stage
    assign pixel_stall = clear_busy || (({1'b0, q_count_reg} + {2'b00, s1_valid_reg}) >= 3'd3);
    assign pix_acc     = pixel_valid && !pixel_stall;

    seom_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (pix_acc),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .learn_frames (learn_frames_reg),
        .decay_period (decay_period_reg),
        .px           (px0)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= pix_acc;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
            px1_reg <= px0;
    end

    seom_bg u_bg (
        .clk            (clk),
        .accept         (pix_acc),
        .s1_valid       (s1_valid_reg),
        .px0            (px0),
        .px1            (px1_reg),
        .gradient_x     (gradient_x),
        .gradient_y     (gradient_y),
        .fore_threshold (fore_threshold_reg),
        .learn_rate     (learn_rate_reg),
        .fore_x         (fx),
        .fore_y         (fy)
    );

    seom_cnt u_cnt (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (pix_acc),
        .s1_valid         (s1_valid_reg),
        .px0              (px0),
        .px1              (px1_reg),
        .fore             (fx || fy),
        .static_time      (static_time_reg),
        .half_static_time (half_static_reg),
        .clear_busy       (clear_busy),
        .count            (count)
    );

    // result queue
    always_comb
    begin
        q_in.fore_x          = fx;
        q_in.fore_y          = fy;
        q_in.count           = count;
        q_in.static_pixel    = count > static_time_reg;
        q_in.candidate_pixel = count > half_static_reg;
        q_in.fend            = px1_reg.fend;

        q_out = q_mem[q_rd_reg];
        q_pop = result_valid && !result_stall;
        q_count_next = q_count_reg + 2'(s1_valid_reg) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= '0;
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (s1_valid_reg)
                q_wr_reg <= (q_wr_reg == 2'd2) ? 2'd0 : q_wr_reg + 2'd1;
            if (q_pop)
                q_rd_reg <= (q_rd_reg == 2'd2) ? 2'd0 : q_rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            q_mem[q_wr_reg] <= q_in;
    end

    assign result_valid    = (q_count_reg != '0);
    assign fore_x          = q_out.fore_x;
    assign fore_y          = q_out.fore_y;
    assign static_count    = q_out.count;
    assign static_pixel    = q_out.static_pixel;
    assign candidate_pixel = q_out.candidate_pixel;
    assign frame_end       = q_out.fend;

    // no pixel enters while the counter map is being cleared
    a_no_acc_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !pix_acc)
        else $error("pixel transfer during counter clear");

    // queue plus compute stage never exceed queue depth
    a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_count_reg} + {2'b00, s1_valid_reg}) <= 3'd3)
        else $error("result queue overflow");

    // a transfer in is only taken with room for its result
    a_acc_room: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |-> (({1'b0, q_count_reg} + {2'b00, s1_valid_reg}) <= 3'd2))
        else $error("pixel taken without queue room");

    // every computed result lands in the queue
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !q_pop) |=> (q_count_reg == $past(q_count_reg) + 2'd1))
        else $error("result lost");

endmodule
